>>> design/icph_pkg.sv
// ----------------------------------------------------------------------------
// icph_pkg
// shared types, constants and the ones-complement adder for the checksum unit
// ----------------------------------------------------------------------------
package icph_pkg;

    localparam logic [1:0]  MODE_UDP    = 2'd1;
    localparam logic [1:0]  MODE_TCP    = 2'd2;
    localparam logic [16:0] PROTO_UDP   = 17'd17;
    localparam logic [16:0] PROTO_TCP   = 17'd6;
    localparam logic [16:0] PSEUDO_OFS  = 17'd8;
    localparam int          QUEUE_DEPTH = 2;

    // one queue entry: a completed 16-bit word plus what the back end needs at the end
    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic        add_term;
        logic        err;
        logic [15:0] term;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> design/icph_front.sv
// ----------------------------------------------------------------------------
// icph_front
// pairs bytes into big-endian words, counts the region and forms the
// pseudo-header term on the last byte
// ----------------------------------------------------------------------------
module icph_front #(
    parameter int MAX_REGION_BYTES = 65535
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic [1:0]    i_mode,
    input  logic          i_last,
    output logic          o_push,
    output icph_pkg::t_qent o_entry
);
    import icph_pkg::*;

    localparam int CW = $clog2(MAX_REGION_BYTES + 1);

    logic [CW-1:0] r_count, n_count, count_next;
    logic [1:0]    r_mode, mode_eff;
    logic          r_odd, n_odd;
    logic [7:0]    r_high, n_high;
    logic [16:0]   term_raw;
    logic          pseudo;
    logic          err;

    // mode is taken from the first byte only
    assign mode_eff   = (r_count == '0) ? i_mode : r_mode;
    assign pseudo     = (mode_eff == MODE_UDP) || (mode_eff == MODE_TCP);
    assign count_next = (r_count < CW'(MAX_REGION_BYTES)) ? r_count + CW'(1) : r_count;
    assign err        = pseudo && (count_next < CW'(8));
    assign term_raw   = 17'(count_next) + ((mode_eff == MODE_UDP) ? PROTO_UDP : PROTO_TCP)
                        - PSEUDO_OFS;

    always_comb begin
        o_push           = i_accept && (r_odd || i_last);
        o_entry.word     = r_odd ? {r_high, i_byte} : {i_byte, 8'h00};
        o_entry.last     = i_last;
        o_entry.add_term = pseudo && !err;
        o_entry.err      = err;
        o_entry.term     = oc_add(term_raw[15:0], {15'd0, term_raw[16]});
    end

    always_comb begin
        n_count = r_count;
        n_odd   = r_odd;
        n_high  = r_high;
        if (i_accept) begin
            if (i_last) begin
                n_count = '0;
                n_odd   = 1'b0;
                n_high  = '0;
            end else begin
                n_count = count_next;
                n_odd   = !r_odd;
                n_high  = r_odd ? r_high : i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_odd   <= 1'b0;
            r_high  <= '0;
            r_mode  <= '0;
        end else begin
            r_count <= n_count;
            r_odd   <= n_odd;
            r_high  <= n_high;
            if (i_accept && r_count == '0) begin
                r_mode <= i_mode;
            end
        end
    end

endmodule

>>> design/icph_queue.sv
// ----------------------------------------------------------------------------
// icph_queue
// small fifo between the byte front end and the summing back end
// ----------------------------------------------------------------------------
module icph_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  icph_pkg::t_qent i_entry,
    input  logic            i_pop,
    output icph_pkg::t_qent o_entry,
    output icph_pkg::t_qstat o_stat
);
    import icph_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_qent         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_fill;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_entry      = r_mem[r_rd];
    assign o_stat.full  = (r_fill == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

>>> design/icph_back.sv
// ----------------------------------------------------------------------------
// icph_back
// end-around-carry accumulator and result register
// ----------------------------------------------------------------------------
module icph_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  icph_pkg::t_qent i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_checksum,
    output logic            o_length_error
);
    import icph_pkg::*;

    logic [15:0] r_sum;
    logic [15:0] sum_a, fin;
    logic        r_valid;
    logic [15:0] r_checksum;
    logic        r_err;

    // words that are not the last one never wait for the output side
    assign o_pop = i_valid && (!i_entry.last || !r_valid || i_ready);
    assign sum_a = oc_add(r_sum, i_entry.word);
    assign fin   = i_entry.add_term ? oc_add(sum_a, i_entry.term) : sum_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop && i_entry.last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_sum <= i_entry.last ? 16'd0 : sum_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_checksum <= i_entry.err ? 16'd0 : ~fin;
            r_err      <= i_entry.err;
        end
    end

    assign o_valid        = r_valid;
    assign o_checksum     = r_checksum;
    assign o_length_error = r_err;

endmodule

>>> design/internet_checksum_pseudo_header_unit.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_unit
// ones-complement internet checksum with udp/tcp pseudo-header terms
//
//  channel  | direction | tdata               | tuser              | tlast
//  s_axis   | in        | [7:0] data_byte     | [1:0] protocol_mode | last_byte
//  m_axis   | out       | [15:0] checksum     | [0] length_error   | -
//
// one byte per cycle is accepted while the queue is not full; the front end
// pairs bytes and forms the pseudo-header term, a two-entry queue decouples it
// from the summing back end; a checksum is valid once its last word has passed
// through the queue and been popped into the output register
// input keeps flowing while a result waits in the output register, until the
// next last word reaches the queue head and the queue fills (two words)
// synchronous active-low reset clears all region state and empties the queue
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header_unit #(
    parameter int MAX_REGION_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] protocol_mode
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] checksum_value
    output logic [0:0]  m_axis_tuser    // [0] length_error
);
    import icph_pkg::*;

    logic   accept;
    logic   q_push, q_pop;
    t_qent  push_entry, head_entry;
    t_qstat q_stat;
    logic   len_err;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    icph_front #(
        .MAX_REGION_BYTES(MAX_REGION_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_mode   (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .o_push   (q_push),
        .o_entry  (push_entry)
    );

    icph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    icph_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!q_stat.empty),
        .i_entry        (head_entry),
        .o_pop          (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_checksum     (m_axis_tdata),
        .o_length_error (len_err)
    );

    assign m_axis_tuser = len_err;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("length error with nonzero checksum");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |-> q_push)
        else $error("last byte produced no queue entry");
`endif

endmodule
